// ===== hw/rtl/cleh_pkg.sv =====
// Package for the console line editor with history ring.
// Holds sizes, character codes and result action codes; no dependencies.
`default_nettype none
package cleh_pkg;
  localparam int unsigned LineLen   = 64;
  localparam int unsigned HistDepth = 20;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChBs    = 8'h08;
  localparam logic [7:0] ChDel   = 8'h7F;
  localparam logic [7:0] ChCtrlP = 8'h10;
  localparam logic [7:0] ChCtrlN = 8'h0E;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTilde = 8'h7E;

  typedef enum logic [2:0] {
    ActEcho   = 3'd0,
    ActErase  = 3'd1,
    ActBell   = 3'd2,
    ActDone   = 3'd3,
    ActRedraw = 3'd4,
    ActChar   = 3'd5
  } action_e;
endpackage
`default_nettype wire

// ===== hw/rtl/console_line_editor_history.sv =====
// Top level of the console line editor with history ring.
// Uses cleh_pkg; holds the line buffer, the history text memory and the sequencer.
//
//  channel | dir | fields                        | handshake
//  rx      | in  | rx_char_i                     | rx_valid_i / rx_ready_o
//  tx      | out | action_o, out_char_o, last_o  | tx_valid_o / tx_ready_i
//
// rx_ready_o is high only in idle; each byte is accepted in idle and then decoded,
// and printable, erase, bell and ignored bytes are finished in the decode state.
// Carriage return on a non-empty line emits its characters, checks the length and
// compares the characters against the newest entry and, unless they match, copies
// the line into the ring. Ctrl-P from the line being typed stashes it, then rings
// the bell or recalls; Ctrl-N recalls. A beat held in the tx register stalls these.
// Reset clears line length, slots and ring lengths; ring text is read only below
// a stored length. Both memories are read through registers, one address a cycle.
`default_nettype none
module console_line_editor_history #(
  parameter int unsigned LINE_LEN   = cleh_pkg::LineLen,
  parameter int unsigned HIST_DEPTH = cleh_pkg::HistDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       rx_valid_i,
  output logic            rx_ready_o,
  input  wire logic [7:0] rx_char_i,
  output logic            tx_valid_o,
  input  wire logic       tx_ready_i,
  output logic [2:0]      action_o,
  output logic [7:0]      out_char_o,
  output logic            last_o
);
  localparam int unsigned CW = $clog2(LINE_LEN);       // char index
  localparam int unsigned LW = $clog2(LINE_LEN + 1);   // length
  localparam int unsigned SW = $clog2(HIST_DEPTH);
  localparam int unsigned MD = HIST_DEPTH * LINE_LEN;
  localparam int unsigned AW = $clog2(MD);
  localparam logic [LW-1:0] Cap = LW'(LINE_LEN - 1);
  localparam logic [SW-1:0] SlotMax = SW'(HIST_DEPTH - 1);

  typedef enum logic [7:0] {
    StIdle   = 8'b00000001,
    StDec    = 8'b00000010,  // decode and single-beat answers
    StDone   = 8'b00000100,  // emit characters of finished line
    StCmpLen = 8'b00001000,  // length check against newest entry
    StCmp    = 8'b00010000,  // character compare with newest entry
    StStore  = 8'b00100000,  // copy line into a slot
    StPrev   = 8'b01000000,  // Ctrl-P: bell or redraw
    StRec    = 8'b10000000   // recall capture and echo
  } state_e;

  typedef enum logic [1:0] {
    AfterStoreDone = 2'd0,  // end of line: advance write slot
    AfterStorePrev = 2'd1   // Ctrl-P: go on to recall
  } after_e;

  state_e          state_q, state_d;
  after_e          after_q, after_d;
  logic [7:0]      ch_q, ch_d;
  logic [7:0]      edit_mem [LINE_LEN];
  logic [7:0]      ring_mem [MD];
  logic [LW-1:0]   ring_len_q [HIST_DEPTH];
  logic [LW-1:0]   elen_q, elen_d;
  logic [LW-1:0]   idx_q, idx_d;
  logic [LW-1:0]   idx_nx;
  logic [SW-1:0]   wslot_q, wslot_d, bslot_q, bslot_d, tslot_q, tslot_d;
  logic [7:0]      ring_rd_q;
  logic [7:0]      edit_rd_q;
  logic            tx_valid_q, tx_valid_d;
  logic [2:0]      act_q, act_d;
  logic [7:0]      och_q, och_d;
  logic            last_q, last_d;

  // memory controls
  logic            ring_we, edit_we;
  logic [CW-1:0]   edit_wa, edit_ra;
  logic [7:0]      edit_wd;
  logic            len_we;
  logic [SW-1:0]   len_wa;
  logic [LW-1:0]   len_wd;

  // shared unit: slot*LINE_LEN + index address adder, for ring reads and writes
  logic [SW-1:0]   au_slot;
  logic [CW-1:0]   au_idx;
  logic [AW-1:0]   au_addr;
  assign au_addr = AW'(au_slot * LINE_LEN) + AW'(au_idx);

  function automatic logic [SW-1:0] prev_s(input logic [SW-1:0] s);
    return (s == '0) ? SlotMax : s - 1'b1;
  endfunction
  function automatic logic [SW-1:0] next_s(input logic [SW-1:0] s);
    return (s == SlotMax) ? '0 : s + 1'b1;
  endfunction

  logic [SW-1:0] pslot, nslot, wprev;
  assign pslot = prev_s(bslot_q);
  assign nslot = next_s(bslot_q);
  assign wprev = prev_s(wslot_q);
  assign idx_nx = idx_q + 1'b1;

  logic out_free;
  assign out_free = !tx_valid_q || tx_ready_i;

  logic [7:0] eff_ch;
  assign eff_ch = (ch_q == cleh_pkg::ChTab) ? cleh_pkg::ChSpace : ch_q;

  assign rx_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q; after_d = after_q; ch_d = ch_q;
    elen_d = elen_q; idx_d = idx_q; wslot_d = wslot_q; bslot_d = bslot_q;
    tslot_d = tslot_q;
    tx_valid_d = tx_valid_q && !tx_ready_i;
    act_d = act_q; och_d = och_q; last_d = last_q;
    ring_we = 1'b0; edit_we = 1'b0; len_we = 1'b0;
    edit_wa = idx_q[CW-1:0]; edit_wd = ring_rd_q; edit_ra = idx_q[CW-1:0];
    len_wa = tslot_q; len_wd = elen_q;
    au_slot = tslot_q; au_idx = idx_q[CW-1:0];
    case (state_q)
      StIdle: begin
        if (rx_valid_i) begin
          ch_d = rx_char_i; state_d = StDec;
        end
      end
      StDec: begin
        if (out_free) begin
          state_d = StIdle;
          case (ch_q)
            cleh_pkg::ChCr: begin
              tx_valid_d = 1'b1; act_d = cleh_pkg::ActDone; och_d = '0;
              last_d = (elen_q == '0); idx_d = '0; edit_ra = '0;
              if (elen_q == '0) begin
                bslot_d = wslot_q;
              end else begin
                state_d = StDone;
              end
            end
            cleh_pkg::ChBs, cleh_pkg::ChDel: begin
              if (elen_q != '0) begin
                tx_valid_d = 1'b1; act_d = cleh_pkg::ActErase; och_d = '0;
                last_d = 1'b1; elen_d = elen_q - 1'b1;
              end
            end
            cleh_pkg::ChCtrlP: begin
              // stash the line being typed before browsing away from it
              if (bslot_q == wslot_q) begin
                tslot_d = wslot_q; idx_d = '0; edit_ra = '0;
                after_d = AfterStorePrev; state_d = StStore;
              end else begin
                state_d = StPrev;
              end
            end
            cleh_pkg::ChCtrlN: begin
              if (bslot_q == wslot_q) begin
                tx_valid_d = 1'b1; act_d = cleh_pkg::ActBell; och_d = '0; last_d = 1'b1;
              end else begin
                bslot_d = nslot; tslot_d = nslot; idx_d = '0;
                au_slot = nslot; au_idx = '0;
                tx_valid_d = 1'b1; act_d = cleh_pkg::ActRedraw; och_d = '0;
                last_d = (ring_len_q[nslot] == '0);
                elen_d = ring_len_q[nslot];
                state_d = (ring_len_q[nslot] == '0) ? StIdle : StRec;
              end
            end
            default: begin
              // printable, tab taken as space; ignored when the line is full
              if ((eff_ch inside {[cleh_pkg::ChSpace : cleh_pkg::ChTilde]}) &&
                  elen_q < Cap) begin
                tx_valid_d = 1'b1; act_d = cleh_pkg::ActEcho; och_d = eff_ch;
                last_d = 1'b1;
                edit_we = 1'b1; edit_wa = elen_q[CW-1:0]; edit_wd = eff_ch;
                elen_d = elen_q + 1'b1;
              end
            end
          endcase
        end
      end
      StDone: begin
        // edit_rd_q holds char idx; read ahead only when the beat goes out
        if (out_free) begin
          tx_valid_d = 1'b1; act_d = cleh_pkg::ActChar; och_d = edit_rd_q;
          last_d = (idx_nx == elen_q);
          idx_d = idx_nx; edit_ra = idx_nx[CW-1:0];
          if (idx_nx == elen_q) state_d = StCmpLen;
        end
      end
      StCmpLen: begin
        idx_d = '0; edit_ra = '0; au_slot = wprev; au_idx = '0;
        if (ring_len_q[wprev] != elen_q) begin
          tslot_d = wslot_q; after_d = AfterStoreDone; state_d = StStore;
        end else begin
          tslot_d = wprev; state_d = StCmp;
        end
      end
      StCmp: begin
        if (ring_rd_q != edit_rd_q) begin
          tslot_d = wslot_q; idx_d = '0; edit_ra = '0;
          after_d = AfterStoreDone; state_d = StStore;
        end else if (idx_nx == elen_q) begin
          // identical to newest: nothing stored
          bslot_d = wslot_q; elen_d = '0; state_d = StIdle;
        end else begin
          idx_d = idx_nx; edit_ra = idx_nx[CW-1:0]; au_idx = idx_nx[CW-1:0];
        end
      end
      StStore: begin
        if (idx_q < elen_q) begin
          ring_we = 1'b1;
          idx_d = idx_nx; edit_ra = idx_nx[CW-1:0];
        end else begin
          len_we = 1'b1; len_wa = tslot_q; len_wd = elen_q;
          if (after_q == AfterStoreDone) begin
            wslot_d = next_s(wslot_q); bslot_d = next_s(wslot_q);
            elen_d = '0; state_d = StIdle;
          end else begin
            state_d = StPrev;
          end
        end
      end
      StPrev: begin
        if (out_free) begin
          if (pslot == wslot_q || ring_len_q[pslot] == '0) begin
            tx_valid_d = 1'b1; act_d = cleh_pkg::ActBell; och_d = '0;
            last_d = 1'b1; state_d = StIdle;
          end else begin
            bslot_d = pslot; tslot_d = pslot; elen_d = ring_len_q[pslot];
            idx_d = '0; au_slot = pslot; au_idx = '0;
            tx_valid_d = 1'b1; act_d = cleh_pkg::ActRedraw; och_d = '0;
            last_d = 1'b0; state_d = StRec;
          end
        end
      end
      StRec: begin
        // ring_rd_q holds char idx of the recalled slot
        if (out_free) begin
          edit_we = 1'b1; edit_wa = idx_q[CW-1:0]; edit_wd = ring_rd_q;
          tx_valid_d = 1'b1; act_d = cleh_pkg::ActEcho; och_d = ring_rd_q;
          last_d = (idx_nx == elen_q);
          idx_d = idx_nx; au_idx = idx_nx[CW-1:0];
          if (idx_nx == elen_q) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) ring_mem[au_addr] <= edit_rd_q;
    ring_rd_q <= ring_mem[au_addr];
    if (edit_we) edit_mem[edit_wa] <= edit_wd;
    edit_rd_q <= edit_mem[edit_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; after_q <= AfterStoreDone;
      elen_q <= '0; idx_q <= '0; wslot_q <= '0; bslot_q <= '0; tslot_q <= '0;
      tx_valid_q <= 1'b0;
      for (int i = 0; i < HIST_DEPTH; i++) ring_len_q[i] <= '0;
    end else begin
      state_q <= state_d; after_q <= after_d;
      elen_q <= elen_d; idx_q <= idx_d; wslot_q <= wslot_d; bslot_q <= bslot_d;
      tslot_q <= tslot_d; tx_valid_q <= tx_valid_d;
      if (len_we) ring_len_q[len_wa] <= len_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q <= ch_d; act_q <= act_d; och_q <= och_d; last_q <= last_d;
  end

  assign tx_valid_o = tx_valid_q;
  assign action_o   = act_q;
  assign out_char_o = och_q;
  assign last_o     = last_q;

  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni) elen_q <= Cap)
    else $error("line length beyond capacity");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !rx_ready_o) else $error("ready while busy");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_valid_o && !tx_ready_i) |=>
      (tx_valid_o && $stable(action_o) && $stable(out_char_o) && $stable(last_o)))
    else $error("beat dropped under stall");
endmodule
`default_nettype wire

// ===== dv/console_line_editor_history_tb.sv =====
// Self-checking bench for the console line editor with history ring.
// Depends on cleh_pkg and console_line_editor_history; drives bytes, predicts
// the editor's replies in a behavioural model and compares every tx beat.
`timescale 1ns / 1ps
module console_line_editor_history_tb;
  localparam int unsigned Cap = cleh_pkg::LineLen - 1;

  typedef struct packed {
    logic [2:0] act;
    logic [7:0] ch;
    logic       fin;
  } reply_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       rx_valid = 1'b0;
  logic       rx_ready;
  logic [7:0] rx_char = 8'h00;
  logic       tx_valid;
  logic       tx_ready = 1'b0;
  logic [2:0] action;
  logic [7:0] out_char;
  logic       last;

  console_line_editor_history DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .rx_valid_i(rx_valid), .rx_ready_o(rx_ready), .rx_char_i(rx_char),
    .tx_valid_o(tx_valid), .tx_ready_i(tx_ready),
    .action_o(action), .out_char_o(out_char), .last_o(last)
  );

  always #10 clk = ~clk;

  // Shadow editor state
  logic [7:0] line_buf [cleh_pkg::LineLen];
  int unsigned line_len;
  logic [7:0] hist_text [cleh_pkg::HistDepth][cleh_pkg::LineLen];
  int unsigned hist_len [cleh_pkg::HistDepth];
  int unsigned wr_slot, view_slot;

  logic [7:0] key_queue [$];
  reply_t     reply_queue [$];
  int         mismatches = 0;
  int         stall_hold = 0;
  bit         calm = 1'b0;     // stretch with no random idling
  bit         rx_took = 1'b0;  // rx beat taken at the last rising edge

  function automatic int unsigned prev_slot(int unsigned s);
    return (s == 0) ? cleh_pkg::HistDepth - 1 : s - 1;
  endfunction

  function automatic int unsigned next_slot(int unsigned s);
    return (s + 1 >= cleh_pkg::HistDepth) ? 0 : s + 1;
  endfunction

  function automatic void push_reply(logic [2:0] a, logic [7:0] c);
    reply_t r;
    r.act = a; r.ch = c; r.fin = 1'b0;
    reply_queue.push_back(r);
  endfunction

  function automatic void stash_line(int unsigned s);
    for (int i = 0; i < line_len; i++) hist_text[s][i] = line_buf[i];
    hist_len[s] = line_len;
  endfunction

  function automatic void recall_line(int unsigned s);
    line_len = hist_len[s];
    for (int i = 0; i < line_len; i++) line_buf[i] = hist_text[s][i];
    push_reply(cleh_pkg::ActRedraw, 8'h00);
    for (int i = 0; i < line_len; i++) push_reply(cleh_pkg::ActEcho, line_buf[i]);
  endfunction

  function automatic bit matches_newest();
    int unsigned p;
    p = prev_slot(wr_slot);
    if (hist_len[p] != line_len) return 1'b0;
    for (int i = 0; i < line_len; i++)
      if (hist_text[p][i] != line_buf[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Predict replies for one accepted byte; flags the final one as last.
  function automatic void edit_key(logic [7:0] k);
    int base;
    int unsigned p;
    logic [7:0] c;
    base = reply_queue.size();
    c = k;
    if (k == cleh_pkg::ChCr) begin
      push_reply(cleh_pkg::ActDone, 8'h00);
      for (int i = 0; i < line_len; i++) push_reply(cleh_pkg::ActChar, line_buf[i]);
      if (line_len != 0 && !matches_newest()) begin
        stash_line(wr_slot);
        wr_slot = next_slot(wr_slot);
      end
      view_slot = wr_slot;
      line_len = 0;
    end else if (k == cleh_pkg::ChBs || k == cleh_pkg::ChDel) begin
      if (line_len != 0) begin
        push_reply(cleh_pkg::ActErase, 8'h00);
        line_len--;
      end
    end else if (k == cleh_pkg::ChCtrlP) begin
      if (view_slot == wr_slot) stash_line(wr_slot);
      p = prev_slot(view_slot);
      if (p == wr_slot || hist_len[p] == 0) push_reply(cleh_pkg::ActBell, 8'h00);
      else begin
        view_slot = p;
        recall_line(p);
      end
    end else if (k == cleh_pkg::ChCtrlN) begin
      if (view_slot == wr_slot) push_reply(cleh_pkg::ActBell, 8'h00);
      else begin
        view_slot = next_slot(view_slot);
        recall_line(view_slot);
      end
    end else begin
      if (c == cleh_pkg::ChTab) c = cleh_pkg::ChSpace;
      if (c >= cleh_pkg::ChSpace && c <= cleh_pkg::ChTilde && line_len < Cap) begin
        push_reply(cleh_pkg::ActEcho, c);
        line_buf[line_len] = c;
        line_len++;
      end
    end
    if (reply_queue.size() > base) reply_queue[$].fin = 1'b1;
  endfunction

  // Driver: offer bytes from the queue at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!rx_valid || rx_took) begin
        if (key_queue.size() != 0 && (calm || $urandom_range(99) >= 29)) begin
          rx_char  <= key_queue.pop_front();
          rx_valid <= 1'b1;
        end else begin
          rx_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: long hold-off counted here, else random stalls
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_hold > 0) begin
        stall_hold <= stall_hold - 1;
        tx_ready   <= 1'b0;
      end else begin
        tx_ready <= calm || ($urandom_range(99) >= 29);
      end
    end
  end

  // Monitor: predict on accepted bytes, check accepted replies
  always @(posedge clk) begin
    reply_t r;
    if (rst_n) begin
      rx_took <= rx_valid && rx_ready;
      if (rx_valid && rx_ready) edit_key(rx_char);
      if (tx_valid && tx_ready) begin
        if (reply_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat: act=%0d ch=%02h last=%0b", action, out_char, last);
        end else begin
          r = reply_queue.pop_front();
          if (action !== r.act || out_char !== r.ch || last !== r.fin) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp act=%0d ch=%02h last=%0b, got act=%0d ch=%02h last=%0b",
                       r.act, r.ch, r.fin, action, out_char, last);
          end
        end
      end
    end
  end

  task automatic type_line(int unsigned n);
    for (int i = 0; i < n; i++) key_queue.push_back(8'($urandom_range(8'h20, 8'h7E)));
    key_queue.push_back(cleh_pkg::ChCr);
  endtask

  task automatic wait_drained();
    while (key_queue.size() != 0 || rx_valid || reply_queue.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int pick;
    line_len = 0; wr_slot = 0; view_slot = 0;
    for (int i = 0; i < cleh_pkg::HistDepth; i++) hist_len[i] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: empty-line cases, bells, extremes, ignored bytes
    key_queue = '{cleh_pkg::ChBs, cleh_pkg::ChDel, cleh_pkg::ChCtrlP, cleh_pkg::ChCtrlN,
                  cleh_pkg::ChCr, 8'h00, 8'hFF, 8'h80, 8'h1F, cleh_pkg::ChSpace,
                  cleh_pkg::ChTilde, cleh_pkg::ChTab, 8'h41, cleh_pkg::ChBs,
                  cleh_pkg::ChCr, cleh_pkg::ChCtrlP, cleh_pkg::ChCtrlP,
                  cleh_pkg::ChCtrlN, cleh_pkg::ChCtrlN, 8'h5A, cleh_pkg::ChDel,
                  cleh_pkg::ChCr};
    wait_drained();

    // Full line plus overflow bytes, done while tx held off to fill the block
    for (int i = 0; i < cleh_pkg::LineLen + 2; i++)
      key_queue.push_back(8'($urandom_range(8'h21, 8'h7E)));
    stall_hold = 400;
    key_queue.push_back(cleh_pkg::ChCr);
    key_queue.push_back(cleh_pkg::ChCtrlP);
    key_queue.push_back(cleh_pkg::ChCr);   // same as newest: not stored again
    wait_drained();

    // Calm stretch: no idling on either side
    calm = 1'b1;
    repeat (10) type_line($urandom_range(1, 6));
    wait_drained();
    calm = 1'b0;

    // Random: mostly words, browsing and edits, some noise
    for (int i = 0; i < 70; i++) begin
      pick = $urandom_range(99);
      if (pick < 45) key_queue.push_back(8'($urandom_range(8'h20, 8'h7E)));
      else if (pick < 55) key_queue.push_back(cleh_pkg::ChCr);
      else if (pick < 67) key_queue.push_back(cleh_pkg::ChCtrlP);
      else if (pick < 75) key_queue.push_back(cleh_pkg::ChCtrlN);
      else if (pick < 83)
        key_queue.push_back($urandom_range(1) ? cleh_pkg::ChBs : cleh_pkg::ChDel);
      else if (pick < 86) key_queue.push_back(cleh_pkg::ChTab);
      else if (pick < 90) type_line($urandom_range(0, 3) == 0 ? Cap + 1 : $urandom_range(1, 8));
      else key_queue.push_back(8'($urandom_range(255)));
    end
    wait_drained();
    repeat (300) @(posedge clk);
    if (mismatches == 0 && reply_queue.size() == 0) begin
      $display("** console_line_editor_history: PASSED **");
    end else begin
      $display("** console_line_editor_history: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** console_line_editor_history: FAILED **");
    $finish;
  end
endmodule
